/* src/binary_trie_max_xor_assert.svh */
// ----------------------------------------------------------------------------
// Binary trie max-XOR assertion macros
// Property wrappers shared by the trie block, clocked on i_clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_TRIE_MAX_XOR_ASSERT_SVH
`define BINARY_TRIE_MAX_XOR_ASSERT_SVH

// same-cycle implication
`define BTMX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTMX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/btmx_pkg.sv */
// ----------------------------------------------------------------------------
// btmx_pkg
// Opcodes, status codes and field widths of the binary trie max-XOR block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btmx_pkg;

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int RESULT_W = 32;

    typedef logic [OPCODE_W-1:0] t_opcode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_opcode OP_INSERT = 2'd0;
    localparam t_opcode OP_QUERY  = 2'd1;
    localparam t_opcode OP_CLEAR  = 2'd2;

    localparam t_status ST_INSERTED = 3'd0;
    localparam t_status ST_FULL     = 3'd1;
    localparam t_status ST_ANSWERED = 3'd2;
    localparam t_status ST_EMPTY    = 3'd3;
    localparam t_status ST_CLEARED  = 3'd4;

endpackage

/* src/btmx_ram.sv */
// ----------------------------------------------------------------------------
// btmx_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btmx_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* src/binary_trie_max_xor.sv */
// Insert and query walk one trie level per cycle, one node memory access each.
// Query walks the levels and answers; clear and empty query skip the walk.
// Insert steps: walk, parent link, chain of new nodes.
// One item in flight; the next is taken once the result is in the output reg.
// Synchronous active-low reset: trie empty (root links in flops), count 1,
// running maximum 0. Node memory needs no clearing; new nodes are written.
// ----------------------------------------------------------------------------
// binary_trie_max_xor
// Bitwise trie of keys in a node RAM, answering maximum-XOR queries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_trie_max_xor
    import btmx_pkg::*;
#(
    parameter int KEY_BITS   = 32,
    parameter int NODE_COUNT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [31:0] query_xor, [63:32] running_max
    output logic [2:0]  o_m_axis_tuser    // [2:0] status
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int LINK_W = 2 * IDX_W;
    localparam int CNT_W  = $clog2(NODE_COUNT + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_CHAIN,
        S_HOLD
    } t_state;

    t_state               r_state;
    logic                 r_is_ins;
    logic [KEY_BITS-1:0]  r_key;
    logic [KEY_BITS-1:0]  r_acc;
    logic [LVL_W-1:0]     r_lvl;
    logic                 r_at_root;
    logic [IDX_W-1:0]     r_node;
    logic [LINK_W-1:0]    r_root;
    logic [CNT_W-1:0]     r_nodes_used;
    logic [RESULT_W-1:0]  r_best;
    logic                 r_nonempty;
    t_status              r_res_status;
    logic [RESULT_W-1:0]  r_res_qx;
    logic [RESULT_W-1:0]  r_res_max;

    logic [LINK_W-1:0]    w_rdata;
    logic [LINK_W-1:0]    w_cur;
    logic                 w_b;
    logic [IDX_W-1:0]     w_c_same;
    logic [IDX_W-1:0]     w_c_opp;
    logic [IDX_W-1:0]     w_new_idx;
    logic [IDX_W-1:0]     w_nxt_idx;
    logic [LINK_W-1:0]    w_par_links;
    logic [LINK_W-1:0]    w_chain_links;
    logic [SUM_W-1:0]     w_need;
    logic                 w_full;
    logic [LVL_W-1:0]     w_lvl_dn;
    logic                 w_take_opp;
    logic [KEY_BITS-1:0]  w_acc_nx;
    logic [RESULT_W-1:0]  w_qx;
    logic [RESULT_W-1:0]  n_best;
    logic [IDX_W-1:0]     w_next;
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    logic [LINK_W-1:0]    w_wdata;
    logic                 w_in_acc;
    logic                 w_out_free;

    // links: [IDX_W-1:0] child for bit 0, upper half child for bit 1; 0 = none
    always_comb begin
        w_cur       = r_at_root ? r_root : w_rdata;
        w_b         = r_key[r_lvl];
        w_c_same    = w_b ? w_cur[LINK_W-1:IDX_W] : w_cur[IDX_W-1:0];
        w_c_opp     = w_b ? w_cur[IDX_W-1:0] : w_cur[LINK_W-1:IDX_W];
        w_new_idx   = r_nodes_used[IDX_W-1:0];
        w_nxt_idx   = w_new_idx + 1'b1;
        w_par_links = w_b ? {w_new_idx, w_cur[IDX_W-1:0]}
                          : {w_cur[LINK_W-1:IDX_W], w_new_idx};
        w_need      = SUM_W'(r_nodes_used) + SUM_W'(r_lvl) + SUM_W'(1);
        w_full      = w_need > SUM_W'(NODE_COUNT);
        w_lvl_dn    = r_lvl - 1'b1;
        if (r_lvl == '0) begin
            w_chain_links = '0;
        end else if (r_key[w_lvl_dn]) begin
            w_chain_links = {w_nxt_idx, IDX_W'(0)};
        end else begin
            w_chain_links = {IDX_W'(0), w_nxt_idx};
        end
        w_take_opp  = (w_c_opp != '0);
        w_acc_nx    = r_acc | (w_take_opp ? (KEY_BITS'(1) << r_lvl) : '0);
        w_qx        = RESULT_W'(w_acc_nx);
        n_best      = (w_qx > r_best) ? w_qx : r_best;
        if (r_is_ins || !w_take_opp) begin
            w_next = w_c_same;
        end else begin
            w_next = w_c_opp;
        end
        w_we    = (r_state == S_CHAIN) ||
                  ((r_state == S_WALK) && r_is_ins && (w_c_same == '0) &&
                   !w_full && !r_at_root);
        w_waddr = (r_state == S_CHAIN) ? w_new_idx : r_node;
        w_wdata = (r_state == S_CHAIN) ? w_chain_links : w_par_links;
    end

    btmx_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_next),
        .o_rdata (w_rdata)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !o_m_axis_tvalid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_root          <= '0;
            r_nodes_used    <= CNT_W'(1);
            r_best          <= '0;
            r_nonempty      <= 1'b0;
            o_m_axis_tvalid <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready && (r_state != S_HOLD)) begin
                o_m_axis_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_key     <= KEY_BITS'(i_s_axis_tdata);
                        r_lvl     <= LVL_W'(KEY_BITS - 1);
                        r_at_root <= 1'b1;
                        r_node    <= '0;
                        r_acc     <= '0;
                        r_res_qx  <= '0;
                        r_res_max <= (i_s_axis_tuser == OP_CLEAR) ? '0 : r_best;
                        priority if (i_s_axis_tuser == OP_INSERT) begin
                            r_is_ins <= 1'b1;
                            r_state  <= S_WALK;
                        end else if (i_s_axis_tuser == OP_QUERY) begin
                            r_is_ins <= 1'b0;
                            if (r_nonempty) begin
                                r_state <= S_WALK;
                            end else begin
                                r_res_status <= ST_EMPTY;
                                r_state      <= S_HOLD;
                            end
                        end else if (i_s_axis_tuser == OP_CLEAR) begin
                            r_root       <= '0;
                            r_nodes_used <= CNT_W'(1);
                            r_best       <= '0;
                            r_nonempty   <= 1'b0;
                            r_res_status <= ST_CLEARED;
                            r_state      <= S_HOLD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_WALK: begin
                    r_at_root <= 1'b0;
                    r_node    <= w_next;
                    if (!(r_is_ins && (w_c_same == '0))) begin
                        r_lvl <= w_lvl_dn;
                    end
                    if (r_is_ins) begin
                        if (w_c_same == '0) begin
                            if (w_full) begin
                                r_res_status <= ST_FULL;
                                r_state      <= S_HOLD;
                            end else begin
                                if (r_at_root) begin
                                    r_root <= w_par_links;
                                end
                                r_state <= S_CHAIN;
                            end
                        end else if (r_lvl == '0) begin
                            r_nonempty   <= 1'b1;
                            r_res_status <= ST_INSERTED;
                            r_state      <= S_HOLD;
                        end
                    end else begin
                        r_acc <= w_acc_nx;
                        if ((!w_take_opp && (w_c_same == '0)) || (r_lvl == '0)) begin
                            r_best       <= n_best;
                            r_res_qx     <= w_qx;
                            r_res_max    <= n_best;
                            r_res_status <= ST_ANSWERED;
                            r_state      <= S_HOLD;
                        end
                    end
                end
                S_CHAIN: begin
                    r_nodes_used <= r_nodes_used + 1'b1;
                    r_lvl        <= w_lvl_dn;
                    if (r_lvl == '0) begin
                        r_nonempty   <= 1'b1;
                        r_res_status <= ST_INSERTED;
                        r_state      <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_out_free) begin
                        o_m_axis_tvalid <= 1'b1;
                        o_m_axis_tuser  <= r_res_status;
                        o_m_axis_tdata  <= {r_res_max, r_res_qx};
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`include "binary_trie_max_xor_assert.svh"

    `BTMX_ASSERT_NOW(a_chain_room, r_state == S_CHAIN, r_nodes_used < CNT_W'(NODE_COUNT), "node allocated beyond pool")
    `BTMX_ASSERT_NOW(a_max_covers, o_m_axis_tvalid && (o_m_axis_tuser == ST_ANSWERED), o_m_axis_tdata[63:32] >= o_m_axis_tdata[31:0], "running maximum below query result")
    `BTMX_ASSERT_NOW(a_xor_zero, o_m_axis_tvalid && (o_m_axis_tuser != ST_ANSWERED), o_m_axis_tdata[31:0] == '0, "nonzero xor on non-query result")
    `BTMX_ASSERT_NEXT(a_clear_state, w_in_acc && (i_s_axis_tuser == OP_CLEAR), (r_nodes_used == CNT_W'(1)) && (r_best == '0) && !r_nonempty && (r_root == '0), "clear left trie state")

endmodule

/* tb/tb_binary_trie_max_xor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_trie_max_xor
// Drives insert, query and clear items into the trie block and predicts every
// result with a behavioural trie of its own. Results are checked in order,
// field by field, under several idling and stalling patterns, a long output
// hold-off and a pass that fills the node pool.
// ----------------------------------------------------------------------------

module tb_binary_trie_max_xor;
    import btmx_pkg::*;

    localparam int          KEY_BITS     = 32;
    localparam int          NODE_COUNT   = 4096;
    localparam t_opcode     OP_UNDEFINED = 2'd3;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = KEY_BITS + 8;

    typedef struct packed {
        t_status     status;
        logic [31:0] query_xor;
        logic [31:0] running_max;
    } t_trie_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] value
    logic [1:0]  s_tuser;   // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [31:0] query_xor, [63:32] running_max
    logic [2:0]  m_tuser;   // [2:0] status

    t_trie_result expected_results[$];
    logic [31:0]  sent_keys[$];
    int unsigned  trie_links[NODE_COUNT][2];
    int unsigned  nodes_in_use;
    logic [31:0]  best_xor;
    bit           has_keys;

    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;
    bit          hold_on;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;

    binary_trie_max_xor #(
        .KEY_BITS   (KEY_BITS),
        .NODE_COUNT (NODE_COUNT)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---- trie predictor ----
    function automatic void trie_reset();
        trie_links[0][0] = 0;
        trie_links[0][1] = 0;
        nodes_in_use     = 1;
        best_xor         = '0;
        has_keys         = 1'b0;
    endfunction

    function automatic int unsigned trie_child(input int unsigned node, input bit b);
        int unsigned c;
        c = trie_links[node][b];
        return (c < nodes_in_use) ? c : 0;
    endfunction

    function automatic t_status trie_insert(input logic [31:0] key);
        int unsigned node;
        int unsigned missing;
        int unsigned c;
        node    = 0;
        missing = 0;
        for (int i = KEY_BITS - 1; i >= 0; i--) begin
            c = trie_child(node, key[i]);
            if (c == 0) begin
                missing = i + 1;
                break;
            end
            node = c;
        end
        if (nodes_in_use + missing > NODE_COUNT)
            return ST_FULL;
        node = 0;
        for (int i = KEY_BITS - 1; i >= 0; i--) begin
            c = trie_child(node, key[i]);
            if (c == 0) begin
                c = nodes_in_use;
                trie_links[c][0]         = 0;
                trie_links[c][1]         = 0;
                trie_links[node][key[i]] = c;
                nodes_in_use++;
            end
            node = c;
        end
        has_keys = 1'b1;
        return ST_INSERTED;
    endfunction

    function automatic logic [31:0] trie_best_xor(input logic [31:0] key);
        int unsigned node;
        int unsigned opp;
        int unsigned same;
        logic [31:0] acc;
        node = 0;
        acc  = '0;
        for (int i = KEY_BITS - 1; i >= 0; i--) begin
            opp = trie_child(node, ~key[i]);
            if (opp != 0) begin
                acc[i] = 1'b1;
                node   = opp;
            end else begin
                same = trie_child(node, key[i]);
                if (same == 0)
                    break;
                node = same;
            end
        end
        return acc;
    endfunction

    function automatic void predict_item(input t_opcode op, input logic [31:0] value);
        t_trie_result r;
        r.query_xor = '0;
        case (op)
            OP_INSERT: begin
                r.status = trie_insert(value);
            end
            OP_QUERY: begin
                if (!has_keys) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.query_xor = trie_best_xor(value);
                    if (r.query_xor > best_xor)
                        best_xor = r.query_xor;
                    r.status = ST_ANSWERED;
                end
            end
            OP_CLEAR: begin
                trie_reset();
                r.status = ST_CLEARED;
            end
            default: begin
                return;
            end
        endcase
        r.running_max = best_xor;
        expected_results.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready)
            predict_item(s_tuser, s_tdata);
    end

    // ---- result checker ----
    always @(posedge i_clk) begin
        t_trie_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected item: status %0d query_xor %h running_max %h",
                         $time, m_tuser, m_tdata[31:0], m_tdata[63:32]);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tuser != want.status || m_tdata[31:0] != want.query_xor ||
                        m_tdata[63:32] != want.running_max) begin
                    $display("%0t mismatch: expected status %0d query_xor %h running_max %h",
                             $time, want.status, want.query_xor, want.running_max);
                    $display("%0t           actual   status %0d query_xor %h running_max %h",
                             $time, m_tuser, m_tdata[31:0], m_tdata[63:32]);
                    mismatch_count++;
                end
            end
        end
    end

    // ---- receiver: random stalls plus a long hold-off on request ----
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_on) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_on = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // ---- watchdog ----
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t no item accepted for %0d cycles", $time, quiet_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ---- stimulus ----
    task automatic send_item(input t_opcode op, input logic [31:0] value);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do @(posedge i_clk); while (!s_tready);
    endtask

    function automatic logic [31:0] pick_sent_key();
        return sent_keys[$urandom_range(sent_keys.size() - 1)];
    endfunction

    task automatic send_random_item();
        int unsigned pick;
        int unsigned sub;
        logic [31:0] key;
        pick = $urandom_range(999);
        sub  = $urandom_range(3);
        key  = $urandom;
        if (pick < 3) begin
            send_item(OP_CLEAR, key);
            sent_keys.delete();
        end else if (pick < 25) begin
            send_item(OP_UNDEFINED, key);
        end else if (pick < 625) begin
            if (sent_keys.size() != 0 && sub == 0)
                key = pick_sent_key();
            else if (sent_keys.size() != 0 && sub == 1)
                key = pick_sent_key() ^ 32'($urandom_range(255));
            send_item(OP_INSERT, key);
            if (sent_keys.size() < 512)
                sent_keys.push_back(key);
        end else begin
            if (sent_keys.size() != 0 && sub == 0)
                key = pick_sent_key();
            else if (sent_keys.size() != 0 && sub == 1)
                key = ~pick_sent_key();
            send_item(OP_QUERY, key);
        end
    endtask

    task automatic test_directed();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_item(OP_QUERY,     32'h1234_5678);
        send_item(OP_UNDEFINED, 32'hDEAD_BEEF);
        send_item(OP_CLEAR,     32'h0000_0000);
        send_item(OP_INSERT,    32'h0000_0000);
        send_item(OP_QUERY,     32'h0000_0000);
        send_item(OP_QUERY,     32'hFFFF_FFFF);
        send_item(OP_INSERT,    32'hFFFF_FFFF);
        send_item(OP_QUERY,     32'h0F0F_0F0F);
        send_item(OP_INSERT,    32'hFFFF_FFFF);
        send_item(OP_QUERY,     32'h8000_0000);
        send_item(OP_INSERT,    32'h5555_5555);
        send_item(OP_INSERT,    32'hAAAA_AAAA);
        send_item(OP_QUERY,     32'h0000_0001);
        send_item(OP_UNDEFINED, 32'h0000_0000);
        send_item(OP_CLEAR,     32'hFFFF_FFFF);
        send_item(OP_QUERY,     32'h0000_0000);
        send_item(OP_INSERT,    32'h8000_0000);
        send_item(OP_QUERY,     32'h7FFF_FFFF);
        send_item(OP_INSERT,    32'h0000_0001);
        send_item(OP_QUERY,     32'h8000_0001);
        send_item(OP_CLEAR,     32'h0000_0000);
        send_item(OP_INSERT,    32'h0000_0001);
        send_item(OP_QUERY,     32'h0000_0000);
    endtask

    // fresh keys exhaust the pool; repeats must still succeed once it is full
    task automatic test_pool_full();
        logic [31:0] key;
        tx_idle_pct  = 37;
        rx_stall_pct = 37;
        send_item(OP_CLEAR, $urandom);
        sent_keys.delete();
        for (int i = 0; i < 200; i++) begin
            key = $urandom;
            send_item(OP_INSERT, key);
            sent_keys.push_back(key);
            if (i % 4 == 3)
                send_item(OP_INSERT, pick_sent_key());
            if (i % 8 == 7)
                send_item(OP_QUERY, $urandom);
        end
    endtask

    task automatic test_random(input int unsigned count, input int unsigned idle_pct,
                               input int unsigned stall_pct);
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        repeat (count) send_random_item();
    endtask

    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_on      = 1'b1;
        repeat (12) send_random_item();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= OP_INSERT;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        hold_on        = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        trie_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_pool_full();
        test_random(390, 0, 0);
        test_random(390, 77, 0);
        test_backpressure();
        test_random(390, 0, 77);
        test_random(390, 37, 37);

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0t %0d expected items never arrived", $time, expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* binary_trie_max_xor.f */
+incdir+src
src/btmx_pkg.sv
src/btmx_ram.sv
src/binary_trie_max_xor.sv
tb/tb_binary_trie_max_xor.sv
